// File: rtl/core/lpbc_pkg.sv
// ----------------------------------------------------------------------------
// lpbc_pkg: LED pulse / blink controller package
// Command codes, widths, item and result types, time saturation helper.
// ----------------------------------------------------------------------------
package lpbc_pkg;

   // counter width for elapsed time and phase limits
   localparam int TIME_WIDTH = 32;
   localparam int FIELD_W    = 32;   // width of the time fields of an item
   localparam int CMD_W      = 3;
   localparam int DUTY_W     = 9;
   localparam int CYCREQ_W   = 8;
   localparam int CYCLES_W   = 7;

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
   localparam logic [DUTY_W-1:0]     DUTY_ONE = DUTY_W'(256);

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK       = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_PULSE      = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_BLINK_TIME = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_BLINK_DUTY = CMD_W'(3);
   localparam logic [CMD_W-1:0] CMD_STOP       = CMD_W'(4);

   typedef logic [TIME_WIDTH-1:0] time_type;

   typedef struct packed {
      logic [CMD_W-1:0]           command;
      logic [FIELD_W-1:0]         pulse_length;
      logic [FIELD_W-1:0]         on_ticks;
      logic [FIELD_W-1:0]         off_ticks;
      logic signed [CYCREQ_W-1:0] cycle_request;
      logic [FIELD_W-1:0]         period_ticks;
      logic [DUTY_W-1:0]          duty_fraction;
   } item_type;

   typedef struct packed {
      logic                pin_level;
      logic                lit;
      logic                pulse_running;
      logic                blink_running;
      logic [CYCLES_W-1:0] cycles_remaining;
   } result_type;

   // clamp a field-width time to the counter maximum
   function automatic time_type sat_time(input logic [FIELD_W-1:0] v);
      time_type r;
      if (64'(v) > 64'(TIME_MAX)) begin
         r = TIME_MAX;
      end else begin
         r = TIME_WIDTH'(v);
      end
      return r;
   endfunction

endpackage

// File: rtl/core/lpbc_if.sv
// ----------------------------------------------------------------------------
// lpbc_if: channel interfaces of the LED pulse / blink controller
// Command channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface lpbc_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [lpbc_pkg::CMD_W-1:0]              command;
   logic [lpbc_pkg::FIELD_W-1:0]            pulse_length;
   logic [lpbc_pkg::FIELD_W-1:0]            on_ticks;
   logic [lpbc_pkg::FIELD_W-1:0]            off_ticks;
   logic signed [lpbc_pkg::CYCREQ_W-1:0]    cycle_request;
   logic [lpbc_pkg::FIELD_W-1:0]            period_ticks;
   logic [lpbc_pkg::DUTY_W-1:0]             duty_fraction;

   modport source (output valid, command, pulse_length, on_ticks, off_ticks,
                   cycle_request, period_ticks, duty_fraction, input ready);
   modport sink   (input valid, command, pulse_length, on_ticks, off_ticks,
                   cycle_request, period_ticks, duty_fraction, output ready);
endinterface

interface lpbc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              pin_level;
   logic                              lit;
   logic                              pulse_running;
   logic                              blink_running;
   logic [lpbc_pkg::CYCLES_W-1:0]     cycles_remaining;

   modport source (output valid, pin_level, lit, pulse_running, blink_running,
                   cycles_remaining, input ready);
   modport sink   (input valid, pin_level, lit, pulse_running, blink_running,
                   cycles_remaining, output ready);
endinterface

interface lpbc_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/lpbc_engine.sv
// ----------------------------------------------------------------------------
// lpbc_engine: mode state and per-item update
// Holds the pulse / blink state, applies one item per enabled cycle and
// presents the result that follows from the updated state.
// ----------------------------------------------------------------------------
module lpbc_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  lpbc_pkg::item_type   item,
   input  logic                 active_high,
   output lpbc_pkg::result_type result
);
   import lpbc_pkg::*;

   logic                pulse_mode_ff, pulse_mode_in;
   logic                blink_mode_ff, blink_mode_in;
   logic                limited_ff, limited_in;
   logic [CYCLES_W-1:0] cycles_left_ff, cycles_left_in;
   logic                lit_ff, lit_in;
   time_type            elapsed_ff, elapsed_in;
   time_type            pulse_limit_ff, pulse_limit_in;
   time_type            on_limit_ff, on_limit_in;
   time_type            off_limit_ff, off_limit_in;

   logic [DUTY_W-1:0]           duty;
   logic [FIELD_W+DUTY_W-1:0]   duty_prod;
   logic [FIELD_W-1:0]          duty_on;
   logic [FIELD_W-1:0]          duty_off;
   time_type                    elapsed_inc;
   logic [CYCLES_W-1:0]         cycles_dec;
   logic                        req_limited;

   // on / off times from period and Q8 duty
   always_comb begin
      duty      = (item.duty_fraction > DUTY_ONE) ? DUTY_ONE : item.duty_fraction;
      duty_prod = (FIELD_W+DUTY_W)'(item.period_ticks) * (FIELD_W+DUTY_W)'(duty);
      duty_on   = duty_prod[FIELD_W+7:8];
      duty_off  = item.period_ticks - duty_on;
   end

   assign elapsed_inc = (elapsed_ff < TIME_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign cycles_dec  = cycles_left_ff - 1'b1;
   assign req_limited = !item.cycle_request[CYCREQ_W-1] && (item.cycle_request != '0);

   // next state for one item
   always_comb begin
      pulse_mode_in  = pulse_mode_ff;
      blink_mode_in  = blink_mode_ff;
      limited_in     = limited_ff;
      cycles_left_in = cycles_left_ff;
      lit_in         = lit_ff;
      elapsed_in     = elapsed_ff;
      pulse_limit_in = pulse_limit_ff;
      on_limit_in    = on_limit_ff;
      off_limit_in   = off_limit_ff;
      case (item.command)
         CMD_TICK: begin
            elapsed_in = elapsed_inc;
            if (pulse_mode_ff) begin
               if (elapsed_inc >= pulse_limit_ff) begin
                  pulse_mode_in  = 1'b0;
                  blink_mode_in  = 1'b0;
                  limited_in     = 1'b0;
                  cycles_left_in = '0;
                  lit_in         = 1'b0;
               end
            end else if (blink_mode_ff) begin
               if (lit_ff && elapsed_inc >= on_limit_ff) begin
                  lit_in     = 1'b0;
                  elapsed_in = '0;
               end else if (!lit_ff && elapsed_inc >= off_limit_ff) begin
                  lit_in     = 1'b1;
                  elapsed_in = '0;
                  if (limited_ff) begin
                     cycles_left_in = cycles_dec;
                     // last cycle done: everything off
                     if (cycles_dec == '0) begin
                        pulse_mode_in = 1'b0;
                        blink_mode_in = 1'b0;
                        limited_in    = 1'b0;
                        lit_in        = 1'b0;
                     end
                  end
               end
            end
         end
         CMD_PULSE: begin
            if (!pulse_mode_ff) begin
               pulse_mode_in  = 1'b1;
               blink_mode_in  = 1'b0;
               limited_in     = 1'b0;
               cycles_left_in = '0;
               pulse_limit_in = sat_time(item.pulse_length);
               elapsed_in     = '0;
               lit_in         = 1'b1;
            end
         end
         CMD_BLINK_TIME, CMD_BLINK_DUTY: begin
            if (!blink_mode_ff) begin
               pulse_mode_in  = 1'b0;
               blink_mode_in  = 1'b1;
               limited_in     = req_limited;
               cycles_left_in = req_limited ? item.cycle_request[CYCLES_W-1:0] : '0;
               if (item.command == CMD_BLINK_TIME) begin
                  on_limit_in  = sat_time(item.on_ticks);
                  off_limit_in = sat_time(item.off_ticks);
               end else begin
                  on_limit_in  = sat_time(duty_on);
                  off_limit_in = sat_time(duty_off);
               end
               elapsed_in = '0;
               lit_in     = 1'b1;
            end
         end
         CMD_STOP: begin
            pulse_mode_in  = 1'b0;
            blink_mode_in  = 1'b0;
            limited_in     = 1'b0;
            cycles_left_in = '0;
            lit_in         = 1'b0;
            elapsed_in     = '0;
         end
         default: begin
            // unused codes leave the state alone
         end
      endcase
   end

   // result reflects the state after this item
   always_comb begin
      result.pin_level        = lit_in ? active_high : !active_high;
      result.lit              = lit_in;
      result.pulse_running    = pulse_mode_in;
      result.blink_running    = blink_mode_in;
      result.cycles_remaining = cycles_left_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_mode_ff  <= 1'b0;
         blink_mode_ff  <= 1'b0;
         limited_ff     <= 1'b0;
         cycles_left_ff <= '0;
         lit_ff         <= 1'b0;
         elapsed_ff     <= '0;
         pulse_limit_ff <= '0;
         on_limit_ff    <= '0;
         off_limit_ff   <= '0;
      end else if (en) begin
         pulse_mode_ff  <= pulse_mode_in;
         blink_mode_ff  <= blink_mode_in;
         limited_ff     <= limited_in;
         cycles_left_ff <= cycles_left_in;
         lit_ff         <= lit_in;
         elapsed_ff     <= elapsed_in;
         pulse_limit_ff <= pulse_limit_in;
         on_limit_ff    <= on_limit_in;
         off_limit_ff   <= off_limit_in;
      end
   end

`ifndef ASSERT_OFF
   // the two modes exclude each other
   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(pulse_mode_ff && blink_mode_ff))
      else $error("pulse and blink active together");

   // a limited count exists only while blinking
   a_limited_blink: assert property (@(posedge clock) disable iff (reset)
      (limited_ff || cycles_left_ff != '0) |-> blink_mode_ff)
      else $error("cycle count outside blink mode");

   // limited count never sits at zero
   a_limited_nonzero: assert property (@(posedge clock) disable iff (reset)
      limited_ff |-> (cycles_left_ff != '0))
      else $error("limited count at zero");

   // LED is dark when no mode runs
   a_dark_when_idle: assert property (@(posedge clock) disable iff (reset)
      (!pulse_mode_ff && !blink_mode_ff) |-> !lit_ff)
      else $error("LED lit with no mode");

   // state moves only when an item is applied
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(en) && !$past(reset) |-> $stable(elapsed_ff) && $stable(lit_ff))
      else $error("state changed without an item");
`endif

endmodule

// File: rtl/core/led_pulse_blink_controller.sv
// Timing: an accepted item is registered in the input register, and its result is
// loaded into the output register once the output register is free.
// Throughput: one item per cycle while results are taken; the state update is one
// pass through the update logic (a 32x9 duty multiply being the longest path).
// Reset: synchronous, active high; all modes off, LED dark, active_high = 1.
// ----------------------------------------------------------------------------
// led_pulse_blink_controller: LED pulse / blink controller top level
// Input register, update engine, output register and the active level register.
// ----------------------------------------------------------------------------
module led_pulse_blink_controller (
   input  logic       clock,
   input  logic       reset,
   lpbc_req_if.sink   req_ch,
   lpbc_rsp_if.source rsp_ch,
   lpbc_csr_if.sink   csr_ch
);
   import lpbc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       active_high_ff, active_high_in;
   logic       out_free;
   logic       advance;
   logic       req_take;
   result_type eng_result;

   // handshake: output register frees the input register
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // next values of the input, output and config registers
   always_comb begin
      in_valid_in    = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in     = in_item_ff;
      if (req_take) begin
         in_item_in.command       = req_ch.command;
         in_item_in.pulse_length  = req_ch.pulse_length;
         in_item_in.on_ticks      = req_ch.on_ticks;
         in_item_in.off_ticks     = req_ch.off_ticks;
         in_item_in.cycle_request = req_ch.cycle_request;
         in_item_in.period_ticks  = req_ch.period_ticks;
         in_item_in.duty_fraction = req_ch.duty_fraction;
      end
      rsp_valid_in   = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
      rsp_in         = advance ? eng_result : rsp_ff;
      active_high_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : active_high_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         active_high_ff <= 1'b1;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         active_high_ff <= active_high_in;
      end
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
   end

   // mode state and update
   lpbc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .item        (in_item_ff),
      .active_high (active_high_ff),
      .result      (eng_result)
   );

   // result channel
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.pin_level        = rsp_ff.pin_level;
   assign rsp_ch.lit              = rsp_ff.lit;
   assign rsp_ch.pulse_running    = rsp_ff.pulse_running;
   assign rsp_ch.blink_running    = rsp_ff.blink_running;
   assign rsp_ch.cycles_remaining = rsp_ff.cycles_remaining;

`ifndef ASSERT_OFF
   // a result is loaded only from a held item
   a_load_from_item: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result not loaded after advance");

   // a held item is not overwritten while it waits
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |-> !req_take)
      else $error("input register overrun");

   // pin level agrees with lit and the active level
   a_pin_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.pin_level == (rsp_ff.lit ~^ active_high_ff)))
      else $error("pin level mismatch");
`endif

endmodule
